FILE: rtl/lcmts_pkg.sv
// ----------------------------------------------------------------------------
// lcmts_pkg
// Types, register indexes and constants shared by the load-cell median, tare
// and scale block.
// ----------------------------------------------------------------------------
package lcmts_pkg;

    localparam int WINDOW_LEN_DEF = 7;

    localparam int SAMPLE_W = 24;
    localparam int SCALE_W  = 32;
    localparam int WEIGHT_W = 32;
    // numerator magnitude is |median - offset| * 2^24
    localparam int NUM_W    = 2 * SAMPLE_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BOWL_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOPPER_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOWL_OFFSET  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOPPER_OFFSET = 2'd3;

    localparam logic signed [SCALE_W-1:0]  SCALE_ONE  = 32'sh0001_0000;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_KEEP  = 1'b1;
    localparam logic CH_BOWL   = 1'b0;

    typedef struct packed {
        logic                       action;
        logic                       channel;
        logic                       tare;
        logic signed [SAMPLE_W-1:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic signed [SAMPLE_W-1:0] median_raw;
        logic                       channel_out;
        logic                       was_tare;
        logic signed [SAMPLE_W-1:0] bowl_offset_out;
        logic                       saturated;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic latch_start;
        logic keep;
        logic load_div;
        logic div_step;
        logic finish_tare;
        logic finish_meas;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic tare;
    } sts_t;

endpackage

FILE: rtl/lcmts_ctrl.sv
// ----------------------------------------------------------------------------
// lcmts_ctrl
// Sequencer: takes readings, runs the divider at the end of a measurement
// burst and strobes the result.
// ----------------------------------------------------------------------------
module lcmts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              action,
    input  lcmts_pkg::sts_t   sts,
    output lcmts_pkg::cmd_t   cmd,
    output logic              busy,
    output logic              done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [lcmts_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                          tare_fin_reg, tare_fin_next;
    logic                          done_reg, done_next;
    logic                          accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE) || tare_fin_reg;
    assign done   = done_reg;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        tare_fin_next = 1'b0;
        done_next     = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tare_fin_reg)
                begin
                    cmd.finish_tare = 1'b1;
                    done_next       = 1'b1;
                end
                else if (accept)
                begin
                    if (action == lcmts_pkg::ACT_START)
                    begin
                        cmd.latch_start = 1'b1;
                    end
                    else
                    begin
                        cmd.keep = 1'b1;
                        if (sts.last)
                        begin
                            if (sts.tare)
                                tare_fin_next = 1'b1;
                            else
                                state_next = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP:
            begin
                cmd.load_div = 1'b1;
                step_next    = lcmts_pkg::STEP_W'(lcmts_pkg::DIV_STEPS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                    state_next = ST_FIN;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_FIN:
            begin
                cmd.finish_meas = 1'b1;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            tare_fin_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            tare_fin_reg <= tare_fin_next;
            done_reg     <= done_next;
        end
    end

endmodule

FILE: rtl/lcmts_dp.sv
// ----------------------------------------------------------------------------
// lcmts_dp
// Datapath: configuration registers, sorted insertion window, bit-serial
// restoring divider and result register.
// ----------------------------------------------------------------------------
module lcmts_dp
#(
    parameter int WINDOW_LEN = lcmts_pkg::WINDOW_LEN_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lcmts_pkg::cmd_t                       cmd,
    input  lcmts_pkg::in_t                        item,
    input  logic                                  cfg_we,
    input  logic [lcmts_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [lcmts_pkg::CFG_DATA_W-1:0]      cfg_data,
    output lcmts_pkg::sts_t                       sts,
    output lcmts_pkg::out_t                       result
);

    localparam int CW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int MID = WINDOW_LEN / 2;
    localparam int SW  = lcmts_pkg::SAMPLE_W;
    localparam int NW  = lcmts_pkg::NUM_W;
    localparam int DW  = lcmts_pkg::SCALE_W;

    // window kept in ascending order; entries at or above count are stale
    logic signed [SW-1:0] sorted_reg [WINDOW_LEN];
    logic signed [SW-1:0] sorted_next [WINDOW_LEN];
    logic                 gt       [WINDOW_LEN];
    logic                 gt_prev  [WINDOW_LEN];
    logic signed [SW-1:0] val_prev [WINDOW_LEN];
    logic [CW-1:0]        count_reg;

    logic                 chan_reg;
    logic                 tare_reg;
    logic signed [DW-1:0] bowl_scale_reg;
    logic signed [DW-1:0] hopper_scale_reg;
    logic signed [SW-1:0] bowl_offset_reg;
    logic signed [SW-1:0] hopper_offset_reg;
    logic signed [SW-1:0] offset_now_reg;

    logic [DW-1:0]        rem_reg;
    logic [NW-1:0]        dq_reg;
    logic [DW-1:0]        den_reg;
    logic                 neg_reg;

    lcmts_pkg::out_t      result_reg;

    logic signed [SW-1:0]  median;
    logic signed [SW-1:0]  offset_sel;
    logic signed [DW-1:0]  scale_sel;
    logic signed [DW-1:0]  scale_eff;
    logic signed [SW:0]    diff;
    logic [SW:0]           diff_mag;
    logic [DW-1:0]         scale_mag;
    logic [DW:0]           rem_sh;
    logic [DW:0]           rem_sub;
    logic                  q_bit;
    logic                  sat_pos;
    logic                  sat_neg;
    logic [DW-1:0]         q_low;

    assign median   = sorted_reg[MID];
    assign sts.last = (count_reg == CW'(WINDOW_LEN - 1));
    assign sts.tare = tare_reg;
    assign result   = result_reg;

    // one compare per slot; the new reading lands above every smaller or equal entry
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            gt[i] = (CW'(i) >= count_reg) ? 1'b1 : (sorted_reg[i] > item.sample);
        end
        gt_prev[0]  = 1'b0;
        val_prev[0] = item.sample;
        for (int i = 1; i < WINDOW_LEN; i++)
        begin
            gt_prev[i]  = gt[i-1];
            val_prev[i] = sorted_reg[i-1];
        end
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (CW'(i) > count_reg || !gt[i])
                sorted_next[i] = sorted_reg[i];
            else if (gt_prev[i])
                sorted_next[i] = val_prev[i];
            else
                sorted_next[i] = item.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.keep)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
                sorted_reg[i] <= sorted_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            chan_reg  <= lcmts_pkg::CH_BOWL;
            tare_reg  <= 1'b0;
        end
        else if (cmd.latch_start)
        begin
            count_reg <= '0;
            tare_reg  <= item.tare;
            chan_reg  <= item.tare ? lcmts_pkg::CH_BOWL : item.channel;
        end
        else if (cmd.keep)
        begin
            count_reg <= sts.last ? '0 : count_reg + 1'b1;
        end
    end

    // configuration; the live bowl offset also follows tare bursts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bowl_scale_reg    <= lcmts_pkg::SCALE_ONE;
            hopper_scale_reg  <= lcmts_pkg::SCALE_ONE;
            bowl_offset_reg   <= '0;
            hopper_offset_reg <= '0;
            offset_now_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    lcmts_pkg::REG_BOWL_SCALE:
                        bowl_scale_reg <= cfg_data;
                    lcmts_pkg::REG_HOPPER_SCALE:
                        hopper_scale_reg <= cfg_data;
                    lcmts_pkg::REG_BOWL_OFFSET:
                    begin
                        bowl_offset_reg <= cfg_data[SW-1:0];
                        offset_now_reg  <= cfg_data[SW-1:0];
                    end
                    lcmts_pkg::REG_HOPPER_OFFSET:
                        hopper_offset_reg <= cfg_data[SW-1:0];
                    default:
                        ;
                endcase
            end
            if (cmd.finish_tare)
                offset_now_reg <= median;
        end
    end

    // operand set-up: magnitudes and result sign
    always_comb
    begin
        offset_sel = chan_reg ? hopper_offset_reg : offset_now_reg;
        scale_sel  = chan_reg ? hopper_scale_reg : bowl_scale_reg;
        scale_eff  = (scale_sel == '0) ? lcmts_pkg::SCALE_ONE : scale_sel;
        diff       = (SW+1)'(median) - (SW+1)'(offset_sel);
        diff_mag   = diff[SW] ? (SW+1)'(-diff) : diff;
        scale_mag  = scale_eff[DW-1] ? DW'(-scale_eff) : scale_eff;
    end

    // one quotient bit per step
    always_comb
    begin
        rem_sh  = {rem_reg, dq_reg[NW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        q_bit   = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            rem_reg <= '0;
            dq_reg  <= {diff_mag[SW-1:0], {(NW-SW){1'b0}}};
            den_reg <= scale_mag;
            neg_reg <= diff[SW] ^ scale_eff[DW-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            dq_reg  <= {dq_reg[NW-2:0], q_bit};
        end
    end

    // clamp: positive limit 2^31-1, negative limit 2^31 in magnitude
    always_comb
    begin
        q_low   = dq_reg[DW-1:0];
        sat_pos = (dq_reg[NW-1:DW-1] != '0);
        sat_neg = (dq_reg[NW-1:DW] != '0) || (dq_reg[DW-1] && (dq_reg[DW-2:0] != '0));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_tare)
        begin
            result_reg.weight          <= '0;
            result_reg.median_raw      <= median;
            result_reg.channel_out     <= chan_reg;
            result_reg.was_tare        <= 1'b1;
            result_reg.bowl_offset_out <= median;
            result_reg.saturated       <= 1'b0;
        end
        else if (cmd.finish_meas)
        begin
            if (neg_reg)
            begin
                result_reg.weight    <= sat_neg ? lcmts_pkg::WEIGHT_MIN : DW'(-q_low);
                result_reg.saturated <= sat_neg;
            end
            else
            begin
                result_reg.weight    <= sat_pos ? lcmts_pkg::WEIGHT_MAX : q_low;
                result_reg.saturated <= sat_pos;
            end
            result_reg.median_raw      <= median;
            result_reg.channel_out     <= chan_reg;
            result_reg.was_tare        <= 1'b0;
            result_reg.bowl_offset_out <= offset_now_reg;
        end
    end

endmodule

FILE: rtl/load_cell_median_tare_scaler.sv
// ----------------------------------------------------------------------------
// load_cell_median_tare_scaler
// Median filter over a burst of load-cell readings, bowl tare and
// fixed-point scaling to a saturated Q24.8 weight.
// ----------------------------------------------------------------------------
// A reading is taken when start is high and busy is low. Burst-start readings
// and all but the last kept reading of a burst are taken without raising
// busy. The last kept reading is sorted into the window on its transfer; a
// tare burst then holds busy for one cycle and strobes done as busy falls,
// while a measurement burst holds busy through the prepare, divide and finish
// states, the bit-serial divider producing one quotient bit per cycle, with
// done strobed in the same cycle as busy falls. The result is valid only while
// done is high; the receiver cannot stall it, so it must take every transfer.
// Configuration writes land at once and belong in idle periods.
// ----------------------------------------------------------------------------
module load_cell_median_tare_scaler
#(
    parameter int WINDOW_LEN = lcmts_pkg::WINDOW_LEN_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  lcmts_pkg::in_t                        item,
    output logic                                  done,
    output lcmts_pkg::out_t                       result,
    input  logic                                  cfg_we,
    input  logic [lcmts_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [lcmts_pkg::CFG_DATA_W-1:0]      cfg_data
);

    lcmts_pkg::cmd_t cmd;
    lcmts_pkg::sts_t sts;

    lcmts_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (item.action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    lcmts_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .sts      (sts),
        .result   (result)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_median_tare_scaler testbench
// Feeds bursts of load-cell readings through the start/busy port, predicts each
// median, tare and scaled weight in a local model and compares every done
// strobe field by field. The run steps through several register settings,
// extremes among them, with random idle gaps on the sending side.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     NSAMP         = lcmts_pkg::WINDOW_LEN_DEF;
    localparam int     SW            = lcmts_pkg::SAMPLE_W;
    localparam int     CW            = lcmts_pkg::SCALE_W;
    localparam int     ITEM_TARGET   = 1550;
    localparam int     IDLE_PCT      = 14;
    localparam int     SETTLE_CYCLES = 60;
    localparam longint CYCLE_LIMIT   = 400000;
    localparam int     NUM_PHASES    = 10;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    lcmts_pkg::in_t                      item;
    logic                                done;
    lcmts_pkg::out_t                     result;
    logic                                cfg_we;
    logic [lcmts_pkg::CFG_IDX_W-1:0]     cfg_idx;
    logic [lcmts_pkg::CFG_DATA_W-1:0]    cfg_data;

    load_cell_median_tare_scaler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // local copy of the block's state and registers
    logic signed [SW-1:0] win [NSAMP];
    int                   kept_n;
    logic                 burst_chan;
    logic                 burst_tare;
    logic signed [SW-1:0] bowl_off_live;
    logic signed [SW-1:0] hopper_off;
    logic signed [CW-1:0] bowl_scale;
    logic signed [CW-1:0] hopper_scale;

    lcmts_pkg::out_t pending_weighings[$];
    int     items_sent;
    int     results_seen;
    int     tare_results;
    int     sat_results;
    int     error_count;
    bit     idle_on;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [SW-1:0] window_median();
        logic signed [SW-1:0] v [NSAMP];
        logic signed [SW-1:0] k;
        int                   j;
        v = win;
        for (int i = 1; i < NSAMP; i++)
        begin
            k = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > k)
            begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = k;
        end
        return v[NSAMP / 2];
    endfunction

    function automatic void apply_setting(logic [lcmts_pkg::CFG_IDX_W-1:0] idx,
                                          logic [lcmts_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lcmts_pkg::REG_BOWL_SCALE:    bowl_scale = data;
            lcmts_pkg::REG_HOPPER_SCALE:  hopper_scale = data;
            lcmts_pkg::REG_BOWL_OFFSET:   bowl_off_live = data[SW-1:0];
            lcmts_pkg::REG_HOPPER_OFFSET: hopper_off = data[SW-1:0];
            default: ;
        endcase
    endfunction

    // advance the burst state by one reading; queue a weighing when it completes
    function automatic void weigh_reading(lcmts_pkg::in_t rd);
        logic signed [SW-1:0] med;
        longint               m;
        longint               o;
        longint               num;
        longint               scl;
        longint               q;
        lcmts_pkg::out_t      r;
        if (rd.action == lcmts_pkg::ACT_START)
        begin
            burst_tare = rd.tare;
            burst_chan = rd.tare ? lcmts_pkg::CH_BOWL : rd.channel;
            kept_n = 0;
            return;
        end
        if (kept_n >= NSAMP)
            kept_n = 0;
        win[kept_n] = rd.sample;
        kept_n++;
        if (kept_n < NSAMP)
            return;
        kept_n = 0;
        med = window_median();
        r = '0;
        if (burst_tare)
            bowl_off_live = med;
        else
        begin
            m = longint'(med);
            o = longint'((burst_chan != lcmts_pkg::CH_BOWL) ? hopper_off : bowl_off_live);
            num = (m - o) * 16777216;
            scl = longint'((burst_chan != lcmts_pkg::CH_BOWL) ? hopper_scale : bowl_scale);
            if (scl == 0)
                scl = longint'(lcmts_pkg::SCALE_ONE);
            q = num / scl;
            if (q > lcmts_pkg::WEIGHT_MAX)
            begin
                r.weight = lcmts_pkg::WEIGHT_MAX;
                r.saturated = 1'b1;
            end
            else if (q < lcmts_pkg::WEIGHT_MIN)
            begin
                r.weight = lcmts_pkg::WEIGHT_MIN;
                r.saturated = 1'b1;
            end
            else
                r.weight = q[lcmts_pkg::WEIGHT_W-1:0];
        end
        r.median_raw = med;
        r.channel_out = burst_chan;
        r.was_tare = burst_tare;
        r.bowl_offset_out = bowl_off_live;
        pending_weighings.push_back(r);
    endfunction

    // results are checked before this edge's transfer is predicted
    always @(posedge clk)
    begin
        lcmts_pkg::out_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_weighings.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: unexpected result weight=%0d median=%0d",
                                 result.weight, result.median_raw);
                end
                else
                begin
                    exp_r = pending_weighings.pop_front();
                    results_seen++;
                    if (exp_r.was_tare)
                        tare_results++;
                    if (exp_r.saturated)
                        sat_results++;
                    if (result !== exp_r)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("ERROR: result %0d mismatch", results_seen);
                            $display("  weight   exp %0d got %0d",
                                     exp_r.weight, result.weight);
                            $display("  median   exp %0d got %0d",
                                     exp_r.median_raw, result.median_raw);
                            $display("  chan/tare/sat exp %b%b%b got %b%b%b",
                                     exp_r.channel_out, exp_r.was_tare, exp_r.saturated,
                                     result.channel_out, result.was_tare,
                                     result.saturated);
                            $display("  bowl_off exp %0d got %0d",
                                     exp_r.bowl_offset_out, result.bowl_offset_out);
                        end
                    end
                end
            end
            if (cfg_we)
                apply_setting(cfg_idx, cfg_data);
            if (start && !busy)
                weigh_reading(item);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_weighings.size());
            $display("load_cell_median_tare_scaler test failed");
            $finish;
        end
    end

    task automatic send_reading(input logic act, input logic ch, input logic tr,
                                input logic [SW-1:0] s);
        lcmts_pkg::in_t rd;
        rd.action = act;
        rd.channel = ch;
        rd.tare = tr;
        rd.sample = s;
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= rd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_weighings.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_quiet();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lcmts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lcmts_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SW-1:0] pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return SW'($urandom);
        else if (sel < 75)
            return bowl_off_live + SW'($urandom_range(4000)) - SW'(2000);
        else if (sel < 88)
            return $urandom_range(1) ? 24'h7FFFFF - SW'($urandom_range(255))
                                     : 24'h800000 + SW'($urandom_range(255));
        else
            return SW'($urandom_range(64)) - SW'(32);
    endfunction

    function automatic logic [CW-1:0] pick_scale();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return $urandom;
        else if (sel < 55)
            return $urandom_range(1) ? CW'($urandom_range(1000))
                                     : -CW'($urandom_range(1000));
        else if (sel < 90)
            return lcmts_pkg::SCALE_ONE * $urandom_range(8) + CW'($urandom_range(65535));
        else
            return '0;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // readings kept after reset, before any burst start, use bowl and no tare
    task automatic test_keep_before_start();
        send_reading(lcmts_pkg::ACT_KEEP, 1'b1, 1'b1, 24'h800000);
        send_reading(lcmts_pkg::ACT_KEEP, 1'b0, 1'b0, 24'h7FFFFF);
        send_reading(lcmts_pkg::ACT_KEEP, 1'b1, 1'b0, 24'h555555);
        send_reading(lcmts_pkg::ACT_KEEP, 1'b0, 1'b1, 24'hAAAAAA);
        send_reading(lcmts_pkg::ACT_KEEP, 1'b0, 1'b0, 24'hFFFFFF);
        send_reading(lcmts_pkg::ACT_KEEP, 1'b0, 1'b0, 24'd100);
        send_reading(lcmts_pkg::ACT_KEEP, 1'b0, 1'b0, 24'h7FFF00);
    endtask

    // tare requested on the hopper still tares the bowl
    task automatic test_tare_on_hopper();
        send_reading(lcmts_pkg::ACT_START, 1'b1, 1'b1, SW'($urandom));
        repeat (NSAMP) send_reading(lcmts_pkg::ACT_KEEP, 1'b0, 1'b0,
                                    24'd1000 + SW'($urandom_range(99)));
    endtask

    task automatic test_restart_mid_burst();
        send_reading(lcmts_pkg::ACT_START, 1'b1, 1'b0, SW'($urandom));
        repeat (3) send_reading(lcmts_pkg::ACT_KEEP, 1'b0, 1'b0, 24'h7FFFFF);
        send_reading(lcmts_pkg::ACT_START, 1'b1, 1'b0, SW'($urandom));
        repeat (NSAMP) send_reading(lcmts_pkg::ACT_KEEP, 1'b0, 1'b0, pick_sample());
    endtask

    // a full window with no new start reuses the latched channel and tare
    task automatic test_keep_after_burst();
        repeat (NSAMP) send_reading(lcmts_pkg::ACT_KEEP, 1'b1, 1'b1, pick_sample());
    endtask

    task automatic random_burst();
        int sel;
        sel = $urandom_range(99);
        if (sel < 78)
        begin
            send_reading(lcmts_pkg::ACT_START, rand_bit(), $urandom_range(99) < 15,
                         SW'($urandom));
            repeat (NSAMP) send_reading(lcmts_pkg::ACT_KEEP, rand_bit(), rand_bit(),
                                        pick_sample());
            if ($urandom_range(99) < 3)
                wait_results();
        end
        else if (sel < 83)
            repeat (NSAMP) send_reading(lcmts_pkg::ACT_KEEP, rand_bit(), rand_bit(),
                                        pick_sample());
        else if (sel < 92)
        begin
            send_reading(lcmts_pkg::ACT_START, rand_bit(), rand_bit(), SW'($urandom));
            repeat ($urandom_range(1, NSAMP - 1))
                send_reading(lcmts_pkg::ACT_KEEP, rand_bit(), rand_bit(), pick_sample());
        end
        else
            repeat ($urandom_range(1, 5))
                send_reading(rand_bit(), rand_bit(), rand_bit(), SW'($urandom));
    endtask

    task automatic test_random_traffic();
        logic [lcmts_pkg::CFG_DATA_W-1:0] bs;
        logic [lcmts_pkg::CFG_DATA_W-1:0] hs;
        logic [lcmts_pkg::CFG_DATA_W-1:0] bo;
        logic [lcmts_pkg::CFG_DATA_W-1:0] ho;
        int                               quota;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    bs = 32'h0000_0001;
                    hs = 32'h8000_0000;
                    bo = 32'hFF80_0000;
                    ho = 32'h007F_FFFF;
                end
                1:
                begin
                    bs = '0;
                    hs = '0;
                    bo = 32'h007F_FFFF;
                    ho = 32'hFF80_0000;
                end
                2:
                begin
                    bs = 32'h7FFF_FFFF;
                    hs = 32'hFFFF_FFFF;
                    bo = '0;
                    ho = '0;
                end
                default:
                begin
                    bs = pick_scale();
                    hs = pick_scale();
                    bo = $urandom;
                    ho = $urandom;
                end
            endcase
            wait_quiet();
            write_reg(lcmts_pkg::REG_BOWL_SCALE, bs);
            write_reg(lcmts_pkg::REG_HOPPER_SCALE, hs);
            // leave the tared offset alone in some phases
            if (ph < 3 || $urandom_range(1))
                write_reg(lcmts_pkg::REG_BOWL_OFFSET, bo);
            write_reg(lcmts_pkg::REG_HOPPER_OFFSET, ho);
            idle_on = !(ph == 4 || ph == 5);
            quota = items_sent + (ITEM_TARGET - items_sent) / (NUM_PHASES - ph);
            while (items_sent < quota)
                random_burst();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_idx = lcmts_pkg::REG_BOWL_SCALE;
        cfg_data = '0;
        foreach (win[i])
            win[i] = '0;
        kept_n = 0;
        burst_chan = lcmts_pkg::CH_BOWL;
        burst_tare = 1'b0;
        bowl_off_live = '0;
        hopper_off = '0;
        bowl_scale = lcmts_pkg::SCALE_ONE;
        hopper_scale = lcmts_pkg::SCALE_ONE;
        items_sent = 0;
        results_seen = 0;
        tare_results = 0;
        sat_results = 0;
        error_count = 0;
        idle_on = 1'b1;
        cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_keep_before_start();
        test_tare_on_hopper();
        test_restart_mid_burst();
        test_keep_after_burst();
        test_random_traffic();

        wait_quiet();
        if (pending_weighings.size() != 0)
        begin
            error_count += pending_weighings.size();
            $display("ERROR: %0d results never arrived", pending_weighings.size());
        end
        $display("Sent %0d readings over %0d register settings; %0d bursts completed",
                 items_sent, NUM_PHASES + 1, results_seen);
        $display("  of which %0d tares and %0d saturated weights; %0d errors",
                 tare_results, sat_results, error_count);
        if (error_count == 0)
            $display("load_cell_median_tare_scaler test passed");
        else
            $display("load_cell_median_tare_scaler test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/lcmts_pkg.sv
rtl/lcmts_ctrl.sv
rtl/lcmts_dp.sv
rtl/load_cell_median_tare_scaler.sv
tb/sv/testbench.sv
